@@ sv/slt_pkg.sv @@
package slt_pkg;

  localparam int unsigned ValueW = 32;
  localparam int unsigned StatusW = 2;
  localparam int unsigned OpW = 2;
  localparam int unsigned CountOutW = 5;

  typedef enum logic [OpW-1:0] {
    OpInsert = 2'd0,
    OpRemove = 2'd1,
    OpDrain  = 2'd2,
    OpNone   = 2'd3
  } op_e;

  typedef enum logic [StatusW-1:0] {
    StOk       = 2'd0,
    StFull     = 2'd1,
    StNotFound = 2'd2,
    StEmpty    = 2'd3
  } status_e;

  // Per-cycle control broadcast along the cell row
  typedef struct packed {
    logic ins;  // insert the operand at its sorted place
    logic rem;  // close the gap at the first match
    logic drn;  // shift the whole row towards cell 0
  } slt_ctl_t;

endpackage

@@ sv/slt_cell.sv @@
module slt_cell import slt_pkg::*; #(
  parameter int unsigned Idx = 0,
  parameter int unsigned CntW = 5
) (
  input  logic                     clk_i,
  input  slt_ctl_t                 ctl_i,
  input  logic signed [ValueW-1:0] operand_i,
  input  logic [CntW-1:0]          count_i,
  input  logic signed [ValueW-1:0] left_val_i,
  input  logic                     left_ins_i,
  input  logic signed [ValueW-1:0] right_val_i,
  output logic signed [ValueW-1:0] val_o,
  output logic                     ins_o,
  output logic                     eq_o
);

  logic signed [ValueW-1:0] val_q, val_d;
  logic occ, gt, ge;

  assign occ   = CntW'(Idx) < count_i;
  assign gt    = occ && (val_q > operand_i);
  assign ge    = occ && (val_q >= operand_i);
  assign eq_o  = occ && (val_q == operand_i);
  // first free slot or any held value above the operand
  assign ins_o = gt || (CntW'(Idx) == count_i);
  assign val_o = val_q;

  always_comb begin
    val_d = val_q;
    if (ctl_i.ins && ins_o) begin
      val_d = left_ins_i ? left_val_i : operand_i;
    end else if ((ctl_i.rem && ge) || ctl_i.drn) begin
      val_d = right_val_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

@@ sv/sorted_list_table.sv @@
// Sorted table of up to DEPTH signed 32-bit values, ascending, duplicates kept.
// Command channel: start_i with op_i/value_i is taken on a rising edge where
// busy_o is low. Result channel: result_valid_o marks one result for exactly
// one cycle; the receiver cannot stall and must take it then.
// Insert and remove: one result in the cycle after the command, busy_o stays
// low, so a command may follow every cycle (one command per cycle).
// Drain of n values: n results on consecutive cycles, the first in the cycle
// after the command, the final one flagged by last_o; busy_o is high until the
// last result is shown. Drain of an empty table gives one result, status empty.
// Op code 3 is taken and gives no result.
// The row of cells compares all held values against the operand in parallel;
// each cell keeps its own value or loads the operand, its left or its right
// neighbour's value. The drain rate of one value per cycle is set by shifting
// the row into cell 0. Reset clears the count, the drain state and the output
// strobe; cell contents are not reset and are only read below the count.
module sorted_list_table import slt_pkg::*; #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  output logic                     busy_o,
  input  logic [OpW-1:0]           op_i,
  input  logic signed [ValueW-1:0] value_i,
  output logic                     result_valid_o,
  output logic [StatusW-1:0]       status_o,
  output logic signed [ValueW-1:0] result_value_o,
  output logic [CountOutW-1:0]     entry_count_o,
  output logic                     last_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [CntW-1:0] cnt_q, cnt_d;
  logic            drain_q, drain_d;
  logic            valid_q, valid_d;
  status_e         status_q, status_d;
  logic signed [ValueW-1:0] rv_q, rv_d;
  logic            last_q, last_d;

  logic signed [ValueW-1:0] vals [DEPTH];
  logic [DEPTH-1:0] ins_v, eq_v;
  slt_ctl_t ctl;
  op_e op;
  logic accept, found, full;
  logic signed [ValueW-1:0] min0;

  assign op     = op_e'(op_i);
  assign accept = start_i && !busy_o;
  assign found  = |eq_v;
  assign full   = cnt_q == CntW'(DEPTH);
  assign min0   = (cnt_q != '0) ? vals[0] : '0;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [ValueW-1:0] lv, rv;
    logic li;
    if (g == 0) begin : g_first
      assign lv = '0;
      assign li = 1'b0;
    end else begin : g_mid
      assign lv = vals[g-1];
      assign li = ins_v[g-1];
    end
    if (g == DEPTH - 1) begin : g_end
      assign rv = '0;
    end else begin : g_inner
      assign rv = vals[g+1];
    end
    slt_cell #(.Idx(g), .CntW(CntW)) u_cell (
      .clk_i      (clk_i),
      .ctl_i      (ctl),
      .operand_i  (value_i),
      .count_i    (cnt_q),
      .left_val_i (lv),
      .left_ins_i (li),
      .right_val_i(rv),
      .val_o      (vals[g]),
      .ins_o      (ins_v[g]),
      .eq_o       (eq_v[g])
    );
  end

  always_comb begin
    ctl      = '0;
    cnt_d    = cnt_q;
    drain_d  = drain_q;
    valid_d  = 1'b0;
    status_d = StOk;
    rv_d     = min0;
    last_d   = 1'b1;
    if (drain_q || (accept && op == OpDrain)) begin
      valid_d = 1'b1;
      if (cnt_q == '0) begin
        status_d = StEmpty;
        rv_d     = '0;
        drain_d  = 1'b0;
      end else begin
        ctl.drn = 1'b1;
        rv_d    = vals[0];
        cnt_d   = cnt_q - CntW'(1);
        last_d  = cnt_q == CntW'(1);
        drain_d = cnt_q != CntW'(1);
      end
    end else if (accept) begin
      unique case (op)
        OpInsert: begin
          valid_d = 1'b1;
          if (full) begin
            status_d = StFull;
          end else begin
            ctl.ins = 1'b1;
            cnt_d   = cnt_q + CntW'(1);
            rv_d    = (cnt_q == '0 || value_i < vals[0]) ? value_i : vals[0];
          end
        end
        OpRemove: begin
          valid_d = 1'b1;
          if (found) begin
            ctl.rem = 1'b1;
            cnt_d   = cnt_q - CntW'(1);
            if (eq_v[0]) begin
              rv_d = (cnt_q >= CntW'(2)) ? vals[1] : '0;
            end
          end else begin
            status_d = StNotFound;
          end
        end
        OpDrain, OpNone: begin
          valid_d = 1'b0;
        end
        default: begin
          valid_d = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      drain_q <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      cnt_q   <= cnt_d;
      drain_q <= drain_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    rv_q     <= rv_d;
    last_q   <= last_d;
  end

  assign busy_o         = drain_q;
  assign result_valid_o = valid_q;
  assign status_o       = status_q;
  assign result_value_o = rv_q;
  assign entry_count_o  = CountOutW'(cnt_q);
  assign last_o         = last_q;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(DEPTH))
    else $error("count above depth");

  a_busy_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> result_valid_o && !last_o)
    else $error("drain cycle without a non-final result");

  a_last_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && last_o |-> !busy_o)
    else $error("busy after final result");

  a_drain_reply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && op == OpDrain |=> result_valid_o)
    else $error("drain gave no result");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && op == OpInsert && full |=> cnt_q == CntW'(DEPTH) && status_o == StFull)
    else $error("full insert changed the table");
`endif

endmodule
